>>> sv/tlvd_pkg.sv
// tlvd_pkg: shared types for the tlv record deframer
// parser phase codes and result kind codes; no dependencies

package tlvd_pkg;

    // header length in bytes: 16-bit field number plus 16-bit length
    localparam logic [15:0] HDR_BYTES = 16'd4;

    // parser phase
    typedef enum logic [2:0] {
        PH_SKIP = 3'd0,
        PH_H0   = 3'd1,
        PH_H1   = 3'd2,
        PH_H2   = 3'd3,
        PH_H3   = 3'd4,
        PH_PAY  = 3'd5
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } t_kind;

endpackage

>>> sv/tlv_record_deframer.sv
// tlv_record_deframer: splits a byte-serial message into tag/length/value records
// depends on tlvd_pkg for phase and kind codes

// The block takes one message byte per transaction and gives at most one result per
// byte: a header result (field number and length) when the fourth header byte arrives,
// one payload result per payload byte with the last one marked, or a truncation result
// when a declared length runs past the end of the message. A byte flows through an input
// register and a result register, so the block sustains one byte per cycle while its
// output is not stalled; the single parse stage updates the phase and counters once per
// byte. Bytes that give no result still take their turn in the parse stage. Input stall
// rises only when the input register holds a byte and the result register is full and
// stalled.

module tlv_record_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_message_start,
    input  logic [15:0] i_message_length,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_field_number,
    output logic [15:0] o_record_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_record
);

    // saturating decrement
    function automatic logic [15:0] dec16(input logic [15:0] v);
        dec16 = (v != 16'd0) ? (v - 16'd1) : 16'd0;
    endfunction

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic [15:0] r_in_length;

    // parser state
    tlvd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_field, n_field;
    logic [15:0] r_length, n_length;
    logic [15:0] r_payload_left, n_payload_left;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_field_number;
    logic [15:0] r_record_length;
    logic [7:0]  r_payload_byte;
    logic        r_last;

    // combinational result of the parse stage
    logic        n_emit;
    logic [1:0]  n_kind;
    logic [7:0]  n_pbyte;
    logic        n_last;

    // state after a possible restart
    tlvd_pkg::t_phase ph_eff;
    logic [15:0] rem_eff;
    logic [15:0] pl_eff;
    logic [15:0] len_full;
    logic [15:0] rem_dec;
    logic [15:0] pl_dec;

    logic parse_fire;
    logic in_accept;

    // handshake
    assign parse_fire = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !parse_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (parse_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte   <= i_data_byte;
            r_in_start  <= i_message_start;
            r_in_length <= i_message_length;
        end
    end

    // restart override and shared decrements
    always_comb begin
        if (r_in_start) begin
            ph_eff  = tlvd_pkg::PH_H0;
            rem_eff = r_in_length;
            pl_eff  = 16'd0;
        end else begin
            ph_eff  = r_phase;
            rem_eff = r_remaining;
            pl_eff  = r_payload_left;
        end
        len_full = r_length | {8'h00, r_in_byte};
        rem_dec  = dec16(rem_eff);
        pl_dec   = dec16(pl_eff);
    end

    // next phase and counters
    always_comb begin
        n_phase        = ph_eff;
        n_remaining    = rem_eff;
        n_field        = r_field;
        n_length       = r_length;
        n_payload_left = pl_eff;
        case (ph_eff)
            tlvd_pkg::PH_H0: begin
                if (rem_eff <= tlvd_pkg::HDR_BYTES) begin
                    n_phase     = tlvd_pkg::PH_SKIP;
                    n_remaining = 16'd0;
                end else begin
                    n_field     = {r_in_byte, 8'h00};
                    n_remaining = rem_dec;
                    n_phase     = tlvd_pkg::PH_H1;
                end
            end
            tlvd_pkg::PH_H1: begin
                n_field     = r_field | {8'h00, r_in_byte};
                n_remaining = rem_dec;
                n_phase     = tlvd_pkg::PH_H2;
            end
            tlvd_pkg::PH_H2: begin
                n_length    = {r_in_byte, 8'h00};
                n_remaining = rem_dec;
                n_phase     = tlvd_pkg::PH_H3;
            end
            tlvd_pkg::PH_H3: begin
                n_length = len_full;
                if (rem_dec >= len_full) begin
                    n_remaining    = rem_dec;
                    n_payload_left = len_full;
                    n_phase        = (len_full != 16'd0) ? tlvd_pkg::PH_PAY
                                                         : tlvd_pkg::PH_H0;
                end else begin
                    n_remaining    = 16'd0;
                    n_payload_left = 16'd0;
                    n_phase        = tlvd_pkg::PH_SKIP;
                end
            end
            tlvd_pkg::PH_PAY: begin
                n_payload_left = pl_dec;
                n_remaining    = rem_dec;
                if (pl_dec == 16'd0) begin
                    n_phase = tlvd_pkg::PH_H0;
                end
            end
            default: begin
                n_phase = tlvd_pkg::PH_SKIP;
            end
        endcase
    end

    // result of the parse stage
    always_comb begin
        n_emit  = 1'b0;
        n_kind  = tlvd_pkg::KIND_HEADER;
        n_pbyte = 8'h00;
        n_last  = 1'b0;
        case (ph_eff)
            tlvd_pkg::PH_H3: begin
                n_emit = 1'b1;
                if (rem_dec >= len_full) begin
                    n_kind = tlvd_pkg::KIND_HEADER;
                    n_last = (len_full == 16'd0);
                end else begin
                    n_kind = tlvd_pkg::KIND_TRUNC;
                end
            end
            tlvd_pkg::PH_PAY: begin
                n_emit  = 1'b1;
                n_kind  = tlvd_pkg::KIND_PAYLOAD;
                n_pbyte = r_in_byte;
                n_last  = (pl_eff <= 16'd1);
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tlvd_pkg::PH_SKIP;
            r_remaining    <= 16'd0;
            r_field        <= 16'd0;
            r_length       <= 16'd0;
            r_payload_left <= 16'd0;
        end else if (parse_fire) begin
            r_phase        <= n_phase;
            r_remaining    <= n_remaining;
            r_field        <= n_field;
            r_length       <= n_length;
            r_payload_left <= n_payload_left;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (parse_fire) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (parse_fire && n_emit) begin
            r_kind          <= n_kind;
            r_field_number  <= n_field;
            r_record_length <= n_length;
            r_payload_byte  <= n_pbyte;
            r_last          <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_field_number   = r_field_number;
    assign o_record_length  = r_record_length;
    assign o_payload_byte   = r_payload_byte;
    assign o_last_of_record = r_last;

    // payload bytes are owed only while in the payload phase
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_payload_left != 16'd0) |-> (r_phase == tlvd_pkg::PH_PAY))
        else $error("payload count set outside payload phase");

    // a header with nonzero length leads into the payload phase
    a_header_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (parse_fire && n_emit && (n_kind == tlvd_pkg::KIND_HEADER) && !n_last)
        |=> (r_phase == tlvd_pkg::PH_PAY))
        else $error("header not followed by payload phase");

    // a truncation drops the rest of the message
    a_trunc_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (parse_fire && n_emit && (n_kind == tlvd_pkg::KIND_TRUNC))
        |=> ((r_phase == tlvd_pkg::PH_SKIP) && (r_remaining == 16'd0)))
        else $error("truncation did not drop message");

    // input stalls only when a byte is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

endmodule
